// File: rtl/core/bal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_pkg: shared types and constants for the battery ADC level block
// Field widths, register codes, operation and event codes, pipeline sizing.
// ----------------------------------------------------------------------------
package bal_pkg;

    // Design constants
    localparam int ADC_BITS    = 12;
    localparam int TABLE_DEPTH = 128;

    // Field widths
    localparam int COUNT_W     = 12;
    localparam int ENTRY_IDX_W = 7;
    localparam int PERCENT_W   = 8;
    localparam int MV_W        = 16;
    localparam int EVENT_W     = 2;
    localparam int RES_W       = 24;
    localparam int LIMIT_W     = 16;
    localparam int ENTRIES_W   = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // Table index width
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    // Conversion arithmetic
    localparam int ADC_SCALE  = 600;
    localparam int C6_W       = $clog2((2 ** COUNT_W - 1) * ADC_SCALE + 1);
    localparam int SUM_W      = RES_W + 1;
    localparam int NUM_W      = C6_W + SUM_W;
    localparam int QW         = MV_W + ADC_BITS;
    localparam int RAW_MAX    = 65535;
    localparam int ROUND_HALF = 5;
    localparam int ROUND_STEP = 10;
    localparam int MV_CAP     = 65530;
    localparam int SUM5_W     = MV_W + 1;
    localparam int PROD_W     = 32;
    localparam int RND_RECIP  = 52429;
    localparam int RND_SHIFT  = 19;
    localparam int TENS_W     = 13;

    typedef enum logic {
        OP_CONVERT = 1'b0,
        OP_WRITE   = 1'b1
    } op_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NORMAL  = 2'd0,
        EV_LOW     = 2'd1,
        EV_FULL    = 2'd2,
        EV_INVALID = 2'd3
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP     = 3'd0,
        CFG_BOTTOM  = 3'd1,
        CFG_LOW     = 3'd2,
        CFG_FULL    = 3'd3,
        CFG_FIRST   = 3'd4,
        CFG_STEP    = 3'd5,
        CFG_ENTRIES = 3'd6
    } cfg_idx_t;

    // Per-item data that rides along the whole pipeline
    typedef struct packed {
        op_t                    op;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [PERCENT_W-1:0]   entry_percent;
    } side_t;

endpackage

// File: rtl/core/bal_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_in_if: input channel
// Carries conversion requests and table writes with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bal_in_if
    import bal_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [COUNT_W-1:0]     adc_count;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [PERCENT_W-1:0]   entry_percent;

    modport source (
        output valid, op, adc_count, entry_index, entry_percent,
        input  ready
    );

    modport sink (
        input  valid, op, adc_count, entry_index, entry_percent,
        output ready
    );
endinterface

// File: rtl/core/bal_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_out_if: result channel
// Carries voltage, charge level and event code with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bal_out_if
    import bal_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [MV_W-1:0]      batt_mv;
    logic [PERCENT_W-1:0] charge_pct;
    logic [EVENT_W-1:0]   event_kind;

    modport source (
        output valid, batt_mv, charge_pct, event_kind,
        input  ready
    );

    modport sink (
        input  valid, batt_mv, charge_pct, event_kind,
        output ready
    );
endinterface

// File: rtl/core/battery_adc_to_level_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_adc_to_level_top: ADC count to battery millivolts and charge level
// Pipelined divider scaling, 10 mV rounding, limit classification and a
// state-of-charge lookup in an on-chip table.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in_ch     sink       valid/ready        op, adc_count, entry_index,
//                                          entry_percent
//  out_ch    source     valid/ready        batt_mv, charge_pct,
//                                          event_kind
//  cfg       write      cfg_we             cfg_index, cfg_data
//
//  One transaction enters per cycle while the output is not stalled. The
//  pipeline holds 7 + 16 + ADC_BITS + log2(TABLE_DEPTH) registers (42 here),
//  one per quotient bit in both dividers. Table writes travel the same
//  pipeline and update the table in the lookup stage, so reads and writes
//  keep their arrival order. rst_n clears valid bits and sets the
//  configuration registers to their defaults; the table holds no reset
//  value. A stalled output holds the whole pipeline.
// ----------------------------------------------------------------------------
module battery_adc_to_level_top
    import bal_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bal_in_if.sink                in_ch,
    bal_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Stage positions
    localparam int P_A  = 0;
    localparam int P_B  = 1;
    localparam int P_C  = 2;
    localparam int P_R  = P_C + QW + 1;
    localparam int P_T  = P_R + 1;
    localparam int P_K  = P_T + 1;
    localparam int P_M  = P_K + IDX_W;
    localparam int NSTG = P_M + 1;

    // Configuration registers
    logic [RES_W-1:0]     top_ohm_reg;
    logic [RES_W-1:0]     bottom_ohm_reg;
    logic [LIMIT_W-1:0]   low_mv_reg;
    logic [LIMIT_W-1:0]   full_mv_reg;
    logic [LIMIT_W-1:0]   first_mv_reg;
    logic [LIMIT_W-1:0]   step_mv_reg;
    logic [ENTRIES_W-1:0] entries_reg;

    // Pipeline control and side data
    logic                 adv;
    logic                 vld_reg  [NSTG];
    side_t                side_reg [NSTG];

    // Scaling front
    logic [C6_W-1:0]      a_c6_reg;
    logic [C6_W-1:0]      a_c6_next;
    logic [NUM_W-1:0]     b_num_reg;
    logic [NUM_W-1:0]     b_num_next;
    logic                 both_zero;
    logic                 cfg_bad;
    logic [SUM_W-1:0]     mul_sum;
    logic [RES_W-1:0]     divisor;

    // Voltage divider, stage 0 is the set-up stage
    logic [RES_W-1:0]     qr_rem_reg  [QW+1];
    logic [RES_W-1:0]     qr_rem_next [QW+1];
    logic [QW-1:0]        qr_low_reg  [QW+1];
    logic [QW-1:0]        qr_low_next [QW+1];
    logic [QW-1:0]        qr_quo_reg  [QW+1];
    logic [QW-1:0]        qr_quo_next [QW+1];
    logic                 qr_ovf_reg  [QW+1];
    logic                 qr_ovf_next [QW+1];

    // Rounding
    logic [MV_W-1:0]      raw_mv;
    logic [SUM5_W-1:0]    sum5;
    logic [PROD_W-1:0]    r_prod_reg;
    logic [PROD_W-1:0]    r_prod_next;
    logic [TENS_W-1:0]    tens;
    logic [MV_W:0]        mv_wide;
    logic [MV_W-1:0]      t_mv_reg;
    logic [MV_W-1:0]      t_mv_next;

    // Index divider, stage 0 is the set-up stage
    logic [MV_W-1:0]      rel_mv;
    logic [LIMIT_W-1:0]   ir_rem_reg   [IDX_W+1];
    logic [LIMIT_W-1:0]   ir_rem_next  [IDX_W+1];
    logic [IDX_W-1:0]     ir_low_reg   [IDX_W+1];
    logic [IDX_W-1:0]     ir_low_next  [IDX_W+1];
    logic [IDX_W-1:0]     ir_quo_reg   [IDX_W+1];
    logic [IDX_W-1:0]     ir_quo_next  [IDX_W+1];
    logic                 ir_ovf_reg   [IDX_W+1];
    logic                 ir_ovf_next  [IDX_W+1];
    logic                 ir_below_reg [IDX_W+1];
    logic [MV_W-1:0]      ir_mv_reg    [IDX_W+1];
    event_t               ir_kind_reg  [IDX_W+1];
    event_t               kind_k;

    // Lookup
    logic [IDX_W:0]       used;
    logic [IDX_W-1:0]     last_idx;
    logic [IDX_W-1:0]     m_addr;
    logic [IDX_W-1:0]     wr_addr;
    logic                 wr_en;
    logic [PERCENT_W-1:0] table_mem [TABLE_DEPTH];
    logic [PERCENT_W-1:0] rd_data_reg;

    // Output register
    logic                 out_valid_reg;
    logic [MV_W-1:0]      out_mv_reg;
    event_t               out_kind_reg;
    logic                 out_zero_reg;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_ohm_reg    <= '0;
            bottom_ohm_reg <= '0;
            low_mv_reg     <= '0;
            full_mv_reg    <= LIMIT_W'(RAW_MAX);
            first_mv_reg   <= '0;
            step_mv_reg    <= LIMIT_W'(1);
            entries_reg    <= ENTRIES_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TOP:     top_ohm_reg    <= cfg_data[RES_W-1:0];
                CFG_BOTTOM:  bottom_ohm_reg <= cfg_data[RES_W-1:0];
                CFG_LOW:     low_mv_reg     <= cfg_data[LIMIT_W-1:0];
                CFG_FULL:    full_mv_reg    <= cfg_data[LIMIT_W-1:0];
                CFG_FIRST:   first_mv_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_STEP:    step_mv_reg    <= cfg_data[LIMIT_W-1:0];
                CFG_ENTRIES: entries_reg    <= cfg_data[ENTRIES_W-1:0];
                default:     ;
            endcase
        end
    end

    assign both_zero = (top_ohm_reg == '0) && (bottom_ohm_reg == '0);
    assign cfg_bad   = ((top_ohm_reg == '0) != (bottom_ohm_reg == '0))
                    || (full_mv_reg < low_mv_reg);
    // With no divider the scale is count * 600 / 2^ADC_BITS: divide by one
    assign mul_sum   = both_zero ? SUM_W'(1)
                                 : SUM_W'(top_ohm_reg) + SUM_W'(bottom_ohm_reg);
    assign divisor   = both_zero ? RES_W'(1) : bottom_ohm_reg;

    // ------------------------------------------------------------------
    // Handshake and valid line
    // ------------------------------------------------------------------
    assign adv         = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[P_A] <= in_ch.valid;
            for (int k = 1; k < NSTG; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_valid_reg <= vld_reg[P_M] && (side_reg[P_M].op == OP_CONVERT);
        end
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [RES_W:0]   qt;
        logic             qge;
        logic [LIMIT_W:0] it;
        logic             ige;

        a_c6_next  = C6_W'(in_ch.adc_count) * C6_W'(ADC_SCALE);
        b_num_next = NUM_W'(a_c6_reg) * NUM_W'(mul_sum);

        // Quotient overflows 16 + ADC_BITS bits: raw saturates
        qr_rem_next[0] = RES_W'(b_num_reg >> QW);
        qr_low_next[0] = b_num_reg[QW-1:0];
        qr_quo_next[0] = '0;
        qr_ovf_next[0] = (b_num_reg >> QW) >= NUM_W'(divisor);
        for (int j = 1; j <= QW; j++)
        begin
            qt  = {qr_rem_reg[j-1], qr_low_reg[j-1][QW-1]};
            qge = qt >= {1'b0, divisor};
            qr_rem_next[j] = qge ? RES_W'(qt - {1'b0, divisor}) : RES_W'(qt);
            qr_low_next[j] = QW'({qr_low_reg[j-1], 1'b0});
            qr_quo_next[j] = QW'({qr_quo_reg[j-1], qge});
            qr_ovf_next[j] = qr_ovf_reg[j-1];
        end

        raw_mv      = qr_ovf_reg[QW] ? MV_W'(RAW_MAX) : qr_quo_reg[QW][QW-1:ADC_BITS];
        sum5        = SUM5_W'(raw_mv) + SUM5_W'(ROUND_HALF);
        r_prod_next = PROD_W'(sum5) * PROD_W'(RND_RECIP);

        tens      = TENS_W'(r_prod_reg >> RND_SHIFT);
        mv_wide   = (MV_W+1)'(tens) * (MV_W+1)'(ROUND_STEP);
        t_mv_next = (mv_wide > (MV_W+1)'(MV_CAP)) ? MV_W'(MV_CAP) : mv_wide[MV_W-1:0];

        if (t_mv_reg <= low_mv_reg)
        begin
            kind_k = EV_LOW;
        end
        else if (t_mv_reg >= full_mv_reg)
        begin
            kind_k = EV_FULL;
        end
        else
        begin
            kind_k = EV_NORMAL;
        end

        // A zero step overflows here and selects the last entry
        rel_mv         = t_mv_reg - first_mv_reg;
        ir_rem_next[0] = LIMIT_W'(rel_mv >> IDX_W);
        ir_low_next[0] = rel_mv[IDX_W-1:0];
        ir_quo_next[0] = '0;
        ir_ovf_next[0] = (rel_mv >> IDX_W) >= step_mv_reg;
        for (int j = 1; j <= IDX_W; j++)
        begin
            it  = {ir_rem_reg[j-1], ir_low_reg[j-1][IDX_W-1]};
            ige = it >= {1'b0, step_mv_reg};
            ir_rem_next[j] = ige ? LIMIT_W'(it - {1'b0, step_mv_reg}) : LIMIT_W'(it);
            ir_low_next[j] = IDX_W'({ir_low_reg[j-1], 1'b0});
            ir_quo_next[j] = IDX_W'({ir_quo_reg[j-1], ige});
            ir_ovf_next[j] = ir_ovf_reg[j-1];
        end
    end

    // Clamp entries in use to 1..TABLE_DEPTH
    always_comb
    begin
        if (entries_reg == '0)
        begin
            used = (IDX_W+1)'(1);
        end
        else if (int'(entries_reg) > TABLE_DEPTH)
        begin
            used = (IDX_W+1)'(TABLE_DEPTH);
        end
        else
        begin
            used = (IDX_W+1)'(entries_reg);
        end
        last_idx = IDX_W'(used - (IDX_W+1)'(1));

        if (ir_below_reg[IDX_W])
        begin
            m_addr = '0;
        end
        else if (ir_ovf_reg[IDX_W] || (ir_quo_reg[IDX_W] > last_idx))
        begin
            m_addr = last_idx;
        end
        else
        begin
            m_addr = ir_quo_reg[IDX_W];
        end
    end

    assign wr_addr = IDX_W'(side_reg[P_M].entry_index);
    assign wr_en   = vld_reg[P_M] && (side_reg[P_M].op == OP_WRITE)
                  && (int'(side_reg[P_M].entry_index) < TABLE_DEPTH);

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[P_A] <= '{op:            op_t'(in_ch.op),
                               entry_index:   in_ch.entry_index,
                               entry_percent: in_ch.entry_percent};
            for (int k = 1; k < NSTG; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end

            a_c6_reg  <= a_c6_next;
            b_num_reg <= b_num_next;
            for (int j = 0; j <= QW; j++)
            begin
                qr_rem_reg[j] <= qr_rem_next[j];
                qr_low_reg[j] <= qr_low_next[j];
                qr_quo_reg[j] <= qr_quo_next[j];
                qr_ovf_reg[j] <= qr_ovf_next[j];
            end
            r_prod_reg <= r_prod_next;
            t_mv_reg   <= t_mv_next;

            ir_below_reg[0] <= t_mv_reg < first_mv_reg;
            ir_mv_reg[0]    <= t_mv_reg;
            ir_kind_reg[0]  <= kind_k;
            for (int j = 0; j <= IDX_W; j++)
            begin
                ir_rem_reg[j] <= ir_rem_next[j];
                ir_low_reg[j] <= ir_low_next[j];
                ir_quo_reg[j] <= ir_quo_next[j];
                ir_ovf_reg[j] <= ir_ovf_next[j];
            end
            for (int j = 1; j <= IDX_W; j++)
            begin
                ir_below_reg[j] <= ir_below_reg[j-1];
                ir_mv_reg[j]    <= ir_mv_reg[j-1];
                ir_kind_reg[j]  <= ir_kind_reg[j-1];
            end

            out_mv_reg   <= cfg_bad ? '0 : ir_mv_reg[IDX_W];
            out_kind_reg <= cfg_bad ? EV_INVALID : ir_kind_reg[IDX_W];
            out_zero_reg <= cfg_bad;
        end
    end

    // State-of-charge table: write and read in the lookup stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (wr_en)
            begin
                table_mem[wr_addr] <= side_reg[P_M].entry_percent;
            end
            rd_data_reg <= table_mem[m_addr];
        end
    end

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.batt_mv    = out_mv_reg;
    assign out_ch.charge_pct = out_zero_reg ? '0 : rd_data_reg;
    assign out_ch.event_kind = out_kind_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_from_convert: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |->
            $past(vld_reg[P_M] && (side_reg[P_M].op == OP_CONVERT)))
        else $error("result appeared without a conversion in the lookup stage");

    a_invalid_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.event_kind == EV_INVALID)) |->
            ((out_ch.batt_mv == '0) && (out_ch.charge_pct == '0)))
        else $error("invalid configuration result carries nonzero fields");

    a_voltage_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.batt_mv <= MV_W'(MV_CAP)))
        else $error("voltage above cap");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[P_C+QW] && !qr_ovf_reg[QW] && !cfg_bad) |->
            (qr_rem_reg[QW] < divisor))
        else $error("voltage divider remainder not below divisor");

endmodule
